### hdl/dac_pkg.sv
// ----------------------------------------------------------------------------
// dac_pkg: shared definitions for the double-array Aho-Corasick scanner
// Operation codes, sequencer states, table control groups and result format.
// ----------------------------------------------------------------------------
package dac_pkg;

  localparam int SlotsDef       = 4096;
  localparam int MaxPatternsDef = 1024;
  localparam int MaxRunDef      = 64;

  // Slot numbers are carried wide enough for the largest double array.
  localparam int SlotW = 14;

  localparam logic [SlotW-1:0] RootSlot  = SlotW'(1);
  localparam logic [10:0]      NoPattern = 11'h7FF;
  localparam logic [15:0]      NoneValue = 16'hFFFF;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;

  localparam logic [1:0] CfgCaseFold = 2'd0;
  localparam logic [1:0] CfgPatterns = 2'd1;
  localparam logic [1:0] CfgSlots    = 2'd2;

  typedef enum logic [3:0] {
    OpScan   = 4'd0,
    OpBase   = 4'd1,
    OpCheck  = 4'd2,
    OpFail   = 4'd3,
    OpOutput = 4'd4,
    OpSuffix = 4'd5,
    OpNext   = 4'd6,
    OpLength = 4'd7,
    OpKind   = 4'd8
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StEdgeBase,
    StEdgeTarget,
    StEdgeCheck,
    StOutSlot,
    StOutHead,
    StOutPat,
    StOutLen,
    StFinish
  } state_e;

  typedef struct packed {
    logic base;
    logic check;
    logic fail;
    logic outp;
    logic suffix;
    logic nxt;
    logic len;
    logic kind;
  } tbl_we_t;

  typedef struct packed {
    logic slot;
    logic chk;
    logic pat;
  } tbl_re_t;

  typedef struct packed {
    logic [15:0] kind;
    logic [31:0] stop;
    logic [31:0] start;
    logic [9:0]  id;
  } match_t;

endpackage

### hdl/dac_tables.sv
// ----------------------------------------------------------------------------
// dac_tables: automaton table memories
// Slot and pattern tables, one write and one registered read port each.
// ----------------------------------------------------------------------------
module dac_tables #(
  parameter int SLOTS        = dac_pkg::SlotsDef,
  parameter int MAX_PATTERNS = dac_pkg::MaxPatternsDef,
  localparam int SW = $clog2(SLOTS),
  localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1
) (
  input  logic             clk_i,
  input  dac_pkg::tbl_we_t we_i,
  input  logic [SW-1:0]    wslot_i,
  input  logic [PW-1:0]    wpat_i,
  input  logic [15:0]      wval_i,
  input  logic [10:0]      wout_i,
  input  dac_pkg::tbl_re_t re_i,
  input  logic [SW-1:0]    rslot_i,
  input  logic [SW-1:0]    rchk_i,
  input  logic [PW-1:0]    rpat_i,
  output logic [12:0]      base_o,
  output logic [11:0]      check_o,
  output logic [11:0]      fail_o,
  output logic [10:0]      outp_o,
  output logic [11:0]      suffix_o,
  output logic [10:0]      next_o,
  output logic [15:0]      len_o,
  output logic [15:0]      kind_o
);

  logic [12:0] base_mem   [SLOTS];
  logic [11:0] check_mem  [SLOTS];
  logic [11:0] fail_mem   [SLOTS];
  logic [10:0] outp_mem   [SLOTS];
  logic [11:0] suffix_mem [SLOTS];
  logic [10:0] next_mem   [MAX_PATTERNS];
  logic [15:0] len_mem    [MAX_PATTERNS];
  logic [15:0] kind_mem   [MAX_PATTERNS];

  always_ff @(posedge clk_i) begin
    if (we_i.base) base_mem[wslot_i] <= wval_i[12:0];
    if (re_i.slot) base_o <= base_mem[rslot_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.check) check_mem[wslot_i] <= wval_i[11:0];
    if (re_i.chk) check_o <= check_mem[rchk_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.fail) fail_mem[wslot_i] <= wval_i[11:0];
    if (re_i.slot) fail_o <= fail_mem[rslot_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.outp) outp_mem[wslot_i] <= wout_i;
    if (re_i.slot) outp_o <= outp_mem[rslot_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.suffix) suffix_mem[wslot_i] <= wval_i[11:0];
    if (re_i.slot) suffix_o <= suffix_mem[rslot_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.nxt) next_mem[wpat_i] <= wout_i;
    if (re_i.pat) next_o <= next_mem[rpat_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.len) len_mem[wpat_i] <= wval_i;
    if (re_i.pat) len_o <= len_mem[rpat_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.kind) kind_mem[wpat_i] <= wval_i;
    if (re_i.pat) kind_o <= kind_mem[rpat_i];
  end

endmodule

### hdl/dac_out_buf.sv
// ----------------------------------------------------------------------------
// dac_out_buf: match output register
// Holds one match request for the downstream side of the stream.
// ----------------------------------------------------------------------------
module dac_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dac_pkg::match_t data_i,
  input  logic            last_i,
  input  logic            ovf_i,
  output logic            ready_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [95:0]     m_axis_tdata,
  output logic            m_axis_tlast,
  output logic [0:0]      m_axis_tuser
);

  logic            valid_q;
  dac_pkg::match_t data_q;
  logic            last_q;
  logic            ovf_q;

  assign ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
      last_q <= last_i;
      ovf_q  <= ovf_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {6'b0, data_q};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = ovf_q;

endmodule

### hdl/double_array_aho_corasick_scan_unit.sv
// ----------------------------------------------------------------------------
// double_array_aho_corasick_scan_unit: multi-pattern byte scanner
// Walks a loaded double-array Aho-Corasick automaton and reports matches.
// ----------------------------------------------------------------------------
// A table-write request is decoded and written as it is accepted. A scanned byte
// is taken in, then each transition attempt reads the base, reads the check and
// compares; a failed attempt follows one fail link and tries again. Then each
// output-chain slot visited is read, each match found is reported, and a closing
// step ends the byte. The pace is set by the single registered read port of each
// table, used by one sequencer that visits the slots one after another. The block
// stalls while its output register holds a match that downstream has not taken.
module double_array_aho_corasick_scan_unit #(
  parameter int SLOTS        = dac_pkg::SlotsDef,
  parameter int MAX_PATTERNS = dac_pkg::MaxPatternsDef,
  parameter int MAX_RUN      = dac_pkg::MaxRunDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // text_byte, table_index, table_value
  input  logic        s_axis_tlast,  // end_of_text
  input  logic [3:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // pattern_id, begin_pos, end_pos, pattern_kind
  output logic        m_axis_tlast,  // last_of_run
  output logic [0:0]  m_axis_tuser   // run_overflow
);

  localparam int SW = $clog2(SLOTS);
  localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int LW = dac_pkg::SlotW;
  localparam int CW = $clog2(MAX_RUN + 1);
  localparam logic [16:0] SlotsL = 17'(SLOTS);
  localparam logic [16:0] PatsL  = 17'(MAX_PATTERNS);
  localparam logic [SW:0] StepMax = (SW + 1)'(SLOTS);
  localparam logic [CW-1:0] RunMax = CW'(MAX_RUN);

  logic        fold_q;
  logic [10:0] npat_q;
  logic [12:0] nslot_q;

  dac_pkg::state_e state_q, state_d;
  logic [LW-1:0] s_q, s_d, cur_q, cur_d, cs_q, cs_d;
  logic [13:0]   t_q, t_d;
  logic [31:0]   pos_q, pos_d;
  logic [SW:0]   steps_q, steps_d;
  logic [10:0]   o_q, o_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    byte_q, byte_d;
  logic          eot_q, eot_d;
  logic          pend_v_q, pend_v_d;
  dac_pkg::match_t pend_q, pend_d;

  dac_pkg::tbl_we_t we;
  dac_pkg::tbl_re_t re;
  logic [SW-1:0] rslot, rchk;
  logic [12:0]   base_rd;
  logic [11:0]   check_rd, fail_rd, suffix_rd;
  logic [10:0]   outp_rd, next_rd;
  logic [15:0]   len_rd, kind_rd;

  logic          push, push_last, out_ready;
  dac_pkg::match_t push_data;

  logic        accept;
  logic [7:0]  in_byte, folded;
  logic [11:0] in_idx;
  logic [15:0] in_val;
  logic [10:0] in_out;
  logic        idx_slot_ok, idx_pat_ok;
  logic [13:0] t_sum;
  logic [31:0] rend, len32;
  logic        s_in, cs_in, o_valid;
  logic [LW-1:0] fail_ext, suffix_ext;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_byte = s_axis_tdata[7:0];
  assign in_idx  = s_axis_tdata[19:8];
  assign in_val  = s_axis_tdata[35:20];
  assign in_out  = (in_val == dac_pkg::NoneValue) ? dac_pkg::NoPattern : in_val[10:0];
  assign idx_slot_ok = 17'(in_idx) < SlotsL;
  assign idx_pat_ok  = 17'(in_idx) < PatsL;
  assign folded = (fold_q && in_byte >= dac_pkg::ChUpperA && in_byte <= dac_pkg::ChUpperZ)
                ? in_byte - dac_pkg::ChUpperA + dac_pkg::ChLowerA : in_byte;

  assign s_in    = 17'(s_q) < SlotsL;
  assign cs_in   = 17'(cs_q) < SlotsL;
  assign o_valid = (o_q < npat_q) && (17'(o_q) < PatsL);
  assign t_sum   = 14'(base_rd) + 14'(byte_q);
  assign rend    = pos_q + 32'd1;
  assign len32   = 32'(len_rd);
  assign fail_ext   = LW'(fail_rd);
  assign suffix_ext = LW'(suffix_rd);

  assign s_axis_tready = (state_q == dac_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q  <= 1'b0;
      npat_q  <= 11'd0;
      nslot_q <= 13'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dac_pkg::CfgCaseFold: fold_q  <= cfg_wdata_i[0];
        dac_pkg::CfgPatterns: npat_q  <= cfg_wdata_i[10:0];
        dac_pkg::CfgSlots:    nslot_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Table writes are decoded straight from an accepted request.
  always_comb begin
    we = '0;
    if (accept) begin
      unique case (dac_pkg::op_e'(s_axis_tuser))
        dac_pkg::OpBase:   we.base   = idx_slot_ok;
        dac_pkg::OpCheck:  we.check  = idx_slot_ok;
        dac_pkg::OpFail:   we.fail   = idx_slot_ok;
        dac_pkg::OpOutput: we.outp   = idx_slot_ok;
        dac_pkg::OpSuffix: we.suffix = idx_slot_ok;
        dac_pkg::OpNext:   we.nxt    = idx_pat_ok;
        dac_pkg::OpLength: we.len    = idx_pat_ok;
        dac_pkg::OpKind:   we.kind   = idx_pat_ok;
        default: ;
      endcase
    end
  end

  always_comb begin
    re.slot = ((state_q == dac_pkg::StEdgeBase) && s_in) ||
              ((state_q == dac_pkg::StOutSlot) && cs_in);
    re.chk  = (state_q == dac_pkg::StEdgeTarget);
    re.pat  = (state_q == dac_pkg::StOutPat) && o_valid;
    rslot   = (state_q == dac_pkg::StOutSlot) ? SW'(cs_q) : SW'(s_q);
    rchk    = SW'(t_sum);
  end

  dac_tables #(.SLOTS(SLOTS), .MAX_PATTERNS(MAX_PATTERNS)) u_tables (
    .clk_i    (clk_i),
    .we_i     (we),
    .wslot_i  (SW'(in_idx)),
    .wpat_i   (PW'(in_idx)),
    .wval_i   (in_val),
    .wout_i   (in_out),
    .re_i     (re),
    .rslot_i  (rslot),
    .rchk_i   (rchk),
    .rpat_i   (PW'(o_q)),
    .base_o   (base_rd),
    .check_o  (check_rd),
    .fail_o   (fail_rd),
    .outp_o   (outp_rd),
    .suffix_o (suffix_rd),
    .next_o   (next_rd),
    .len_o    (len_rd),
    .kind_o   (kind_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dac_pkg::StIdle;
      cur_q    <= dac_pkg::RootSlot;
      pos_q    <= 32'd0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      steps_q  <= '0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      pos_q    <= pos_d;
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      steps_q  <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    t_q    <= t_d;
    cs_q   <= cs_d;
    o_q    <= o_d;
    byte_q <= byte_d;
    eot_q  <= eot_d;
    pend_q <= pend_d;
  end

  always_comb begin
    logic miss, chain_end;
    miss      = 1'b0;
    chain_end = 1'b0;
    state_d   = state_q;
    s_d       = s_q;
    t_d       = t_q;
    cur_d     = cur_q;
    pos_d     = pos_q;
    steps_d   = steps_q;
    cs_d      = cs_q;
    o_d       = o_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    byte_d    = byte_q;
    eot_d     = eot_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    push      = 1'b0;
    push_last = 1'b0;
    push_data = pend_q;

    unique case (state_q)
      dac_pkg::StIdle: begin
        if (accept && dac_pkg::op_e'(s_axis_tuser) == dac_pkg::OpScan) begin
          byte_d  = folded;
          eot_d   = s_axis_tlast;
          s_d     = cur_q;
          steps_d = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = dac_pkg::StEdgeBase;
        end
      end
      dac_pkg::StEdgeBase: begin
        if (s_in) state_d = dac_pkg::StEdgeTarget;
        else miss = 1'b1;
      end
      dac_pkg::StEdgeTarget: begin
        t_d = t_sum;
        if (t_sum >= 14'(nslot_q) || 17'(t_sum) >= SlotsL) miss = 1'b1;
        else state_d = dac_pkg::StEdgeCheck;
      end
      dac_pkg::StEdgeCheck: begin
        if (LW'(check_rd) == s_q && t_q != 14'd0) begin
          cur_d   = t_q;
          steps_d = '0;
          state_d = (npat_q != 11'd0) ? dac_pkg::StOutSlot : dac_pkg::StFinish;
          cs_d    = t_q;
        end else begin
          miss = 1'b1;
        end
      end
      dac_pkg::StOutSlot: begin
        state_d = cs_in ? dac_pkg::StOutHead : dac_pkg::StFinish;
      end
      dac_pkg::StOutHead: begin
        o_d     = outp_rd;
        state_d = dac_pkg::StOutPat;
      end
      dac_pkg::StOutPat: begin
        if (o_valid) state_d = dac_pkg::StOutLen;
        else chain_end = 1'b1;
      end
      dac_pkg::StOutLen: begin
        if (len32 > rend) begin
          chain_end = 1'b1;
        end else if (cnt_q >= RunMax) begin
          ovf_d   = 1'b1;
          state_d = dac_pkg::StFinish;
        end else if (!pend_v_q || out_ready) begin
          push         = pend_v_q;
          pend_v_d     = 1'b1;
          pend_d.id    = o_q[9:0];
          pend_d.start = rend - len32;
          pend_d.stop  = rend;
          pend_d.kind  = kind_rd;
          cnt_d        = cnt_q + CW'(1);
          o_d          = next_rd;
          state_d      = dac_pkg::StOutPat;
        end
      end
      dac_pkg::StFinish: begin
        if (!pend_v_q || out_ready) begin
          push      = pend_v_q;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          if (eot_q) begin
            pos_d = 32'd0;
            cur_d = dac_pkg::RootSlot;
          end else begin
            pos_d = rend;
          end
          state_d = dac_pkg::StIdle;
        end
      end
      default: state_d = dac_pkg::StIdle;
    endcase

    // A miss walks one fail link, or gives up at the root or at the step limit.
    if (miss) begin
      if (s_q == dac_pkg::RootSlot || steps_q == StepMax) begin
        cur_d   = dac_pkg::RootSlot;
        cs_d    = dac_pkg::RootSlot;
        steps_d = '0;
        state_d = (npat_q != 11'd0) ? dac_pkg::StOutSlot : dac_pkg::StFinish;
      end else begin
        s_d     = s_in ? fail_ext : dac_pkg::RootSlot;
        steps_d = steps_q + (SW + 1)'(1);
        state_d = dac_pkg::StEdgeBase;
      end
    end

    // The end of one output chain moves on along the dictionary-suffix chain, if a link is left.
    if (chain_end) begin
      if (suffix_ext == '0 || 17'(suffix_ext) >= SlotsL || steps_q == StepMax) begin
        state_d = dac_pkg::StFinish;
      end else begin
        cs_d    = suffix_ext;
        steps_d = steps_q + (SW + 1)'(1);
        state_d = dac_pkg::StOutSlot;
      end
    end
  end

  dac_out_buf u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .data_i        (push_data),
    .last_i        (push_last),
    .ovf_i         (push_last && ovf_q),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_idle_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_v_q)
    else $error("match still pending while accepting requests");

  a_run_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RunMax)
    else $error("match count beyond run limit");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_ready)
    else $error("match pushed into a full output register");

  a_finish_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dac_pkg::StFinish && state_d == dac_pkg::StIdle) |=> !pend_v_q)
    else $error("pending match left after byte finished");

endmodule
